// File: hw/rtl/char_lcd_diff_refresh_defines.svh
// Assertion macros shared by the character LCD refresh block.
// Define ASSERT_OFF to compile all assertions away.
`ifndef CHAR_LCD_DIFF_REFRESH_DEFINES_SVH
`define CHAR_LCD_DIFF_REFRESH_DEFINES_SVH

`ifndef ASSERT_OFF
// Checked on every rising clock edge, switched off while reset is high.
`define CLDR_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);
// Checked on every rising clock edge, reset included.
`define CLDR_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CLDR_ASSERT(label, clk, rst, prop, msg)
`define CLDR_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

// File: hw/rtl/cldr_pkg.sv
package cldr_pkg;

   // Screen geometry: two rows, one byte per cell.
   localparam int CELL_COUNT = 32;
   localparam int CELL_AW    = 5;
   localparam int CHAR_W     = 8;
   localparam int ROW_LENGTH = 16;

   typedef logic [2:0]        req_code_type;
   typedef logic [CHAR_W-1:0] byte_type;
   typedef logic [CELL_AW-1:0] cell_addr_type;

   // Request codes.
   localparam req_code_type REQ_PUT     = 3'd0;
   localparam req_code_type REQ_FILL    = 3'd1;
   localparam req_code_type REQ_BLANK   = 3'd2;
   localparam req_code_type REQ_CLEAR   = 3'd3;
   localparam req_code_type REQ_REFRESH = 3'd4;

   // LCD instruction bytes.
   localparam byte_type CMD_CLEAR   = 8'h01;
   localparam byte_type CMD_ROW0    = 8'h80;
   localparam byte_type CMD_ROW1    = 8'hC0;
   localparam byte_type EMPTY_RESET = 8'h20;

   localparam byte_type ROW_LEN_B = byte_type'(ROW_LENGTH);

   // Set-display-address command for a cell; with a row length of 32 or
   // more every cell falls on the first row.
   function automatic byte_type addr_cmd(cell_addr_type p);
      byte_type p8;
      p8 = {{(CHAR_W-CELL_AW){1'b0}}, p};
      if (p8 < ROW_LEN_B) begin
         return CMD_ROW0 + p8;
      end
      return CMD_ROW1 + (p8 - ROW_LEN_B);
   endfunction

endpackage

// File: hw/rtl/cldr_if.sv
// Request channel: one item per request.
interface cldr_req_if;
   logic                   valid;
   logic                   ready;
   cldr_pkg::req_code_type req_type;
   cldr_pkg::cell_addr_type position;
   cldr_pkg::byte_type     character;

   modport source (output valid, output req_type, output position, output character,
                   input ready);
   modport sink   (input valid, input req_type, input position, input character,
                   output ready);
endinterface

// Result channel: one LCD command, optionally paired with a data byte.
interface cldr_rsp_if;
   logic               valid;
   logic               ready;
   logic               has_data;
   cldr_pkg::byte_type command_byte;
   cldr_pkg::byte_type data_byte;
   logic               last_of_run;

   modport source (output valid, output has_data, output command_byte,
                   output data_byte, output last_of_run, input ready);
   modport sink   (input valid, input has_data, input command_byte,
                   input data_byte, input last_of_run, output ready);
endinterface

// Configuration write channel for the empty character register.
interface cldr_csr_if;
   logic               valid;
   logic               ready;
   cldr_pkg::byte_type empty_char;

   modport source (output valid, output empty_char, input ready);
   modport sink   (input valid, input empty_char, output ready);
endinterface

// File: hw/rtl/cldr_ram.sv
// Simple dual-port RAM: one write port, one read port, registered read data.
module cldr_ram #(
   parameter int WIDTH = cldr_pkg::CHAR_W,
   parameter int DEPTH = cldr_pkg::CELL_COUNT
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: hw/rtl/char_lcd_diff_refresh.sv
// Dirty-cell refresh for a two-row, sixteen-column character LCD. The block
// keeps a pending and a shown copy of the 32-cell screen in two small RAMs.
// Put char writes a single pending cell. Fill and blank pending sweep the
// pending RAM one cell per cycle; clear display sweeps the shown RAM the
// same way and then issues its 0x01 command from a final flush state.
// Refresh issues the home command 0x80, then compares one cell per cycle
// (both RAMs read at the same address) unless the result channel stalls a
// changed cell, and issues a set-address command with the new character
// for each changed cell. After reset, a clearing pass zeroes both copies,
// during which no request item is taken; configuration writes are taken at
// any time.
`include "char_lcd_diff_refresh_defines.svh"

module char_lcd_diff_refresh (
   input logic          clock,
   input logic          reset,
   cldr_req_if.sink     req,
   cldr_rsp_if.source   rsp,
   cldr_csr_if.sink     csr
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SWEEP = 2'd1;
   localparam logic [1:0] ST_SCAN  = 2'd2;
   localparam logic [1:0] ST_FLUSH = 2'd3;

   localparam cldr_pkg::cell_addr_type LAST_CELL =
      cldr_pkg::cell_addr_type'(cldr_pkg::CELL_COUNT - 1);

   logic [1:0]              state_ff, state_in;
   cldr_pkg::cell_addr_type cnt_ff, cnt_in;
   logic                    sweep_pend_ff, sweep_pend_in;
   logic                    sweep_shown_ff, sweep_shown_in;
   logic                    sweep_rsp_ff, sweep_rsp_in;
   cldr_pkg::byte_type      sweep_val_ff, sweep_val_in;
   cldr_pkg::byte_type      empty_ff;

   // Held result: the most recent one of a run, sent once the next is known.
   logic                    hold_has_ff, hold_has_in;
   cldr_pkg::byte_type      hold_cmd_ff, hold_cmd_in;
   cldr_pkg::byte_type      hold_dat_ff, hold_dat_in;

   // Output register.
   logic                    rsp_valid_ff;
   logic                    rsp_has_ff;
   cldr_pkg::byte_type      rsp_cmd_ff;
   cldr_pkg::byte_type      rsp_dat_ff;
   logic                    rsp_last_ff;
   logic                    out_load;
   logic                    out_last;

   // RAM ports.
   logic                    pend_we, shown_we;
   cldr_pkg::cell_addr_type pend_waddr, rd_addr;
   cldr_pkg::byte_type      pend_wdata, shown_wdata;
   cldr_pkg::byte_type      pend_rd, shown_rd;

   logic req_fire;
   logic out_free;
   logic diff;
   logic advance;
   logic last_cell;

   cldr_ram #(.WIDTH(cldr_pkg::CHAR_W), .DEPTH(cldr_pkg::CELL_COUNT)) u_pend_ram (
      .clock (clock),
      .we    (pend_we),
      .waddr (pend_waddr),
      .wdata (pend_wdata),
      .raddr (rd_addr),
      .rdata (pend_rd)
   );

   cldr_ram #(.WIDTH(cldr_pkg::CHAR_W), .DEPTH(cldr_pkg::CELL_COUNT)) u_shown_ram (
      .clock (clock),
      .we    (shown_we),
      .waddr (cnt_ff),
      .wdata (shown_wdata),
      .raddr (rd_addr),
      .rdata (shown_rd)
   );

   assign req.ready = (state_ff == ST_IDLE);
   assign csr.ready = 1'b1;
   assign req_fire  = req.valid && req.ready;
   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign diff      = (pend_rd != shown_rd);
   assign advance   = !diff || out_free;
   assign last_cell = (cnt_ff == LAST_CELL);

   // Sequencer: request decode, sweeps and the refresh scan.
   always_comb begin
      state_in       = state_ff;
      cnt_in         = cnt_ff;
      sweep_pend_in  = sweep_pend_ff;
      sweep_shown_in = sweep_shown_ff;
      sweep_rsp_in   = sweep_rsp_ff;
      sweep_val_in   = sweep_val_ff;
      hold_has_in    = hold_has_ff;
      hold_cmd_in    = hold_cmd_ff;
      hold_dat_in    = hold_dat_ff;
      rd_addr        = cnt_ff;
      pend_we        = 1'b0;
      pend_waddr     = cnt_ff;
      pend_wdata     = sweep_val_ff;
      shown_we       = 1'b0;
      shown_wdata    = sweep_val_ff;
      out_load       = 1'b0;
      out_last       = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            rd_addr = '0;
            if (req_fire) begin
               unique case (req.req_type)
                  cldr_pkg::REQ_PUT: begin
                     pend_we    = 1'b1;
                     pend_waddr = req.position;
                     pend_wdata = req.character;
                  end
                  cldr_pkg::REQ_FILL, cldr_pkg::REQ_BLANK: begin
                     state_in       = ST_SWEEP;
                     cnt_in         = '0;
                     sweep_pend_in  = 1'b1;
                     sweep_shown_in = 1'b0;
                     sweep_rsp_in   = 1'b0;
                     sweep_val_in   = (req.req_type == cldr_pkg::REQ_FILL) ?
                                      req.character : empty_ff;
                  end
                  cldr_pkg::REQ_CLEAR: begin
                     state_in       = ST_SWEEP;
                     cnt_in         = '0;
                     sweep_pend_in  = 1'b0;
                     sweep_shown_in = 1'b1;
                     sweep_rsp_in   = 1'b1;
                     sweep_val_in   = empty_ff;
                     hold_has_in    = 1'b0;
                     hold_cmd_in    = cldr_pkg::CMD_CLEAR;
                     hold_dat_in    = '0;
                  end
                  cldr_pkg::REQ_REFRESH: begin
                     state_in    = ST_SCAN;
                     cnt_in      = '0;
                     hold_has_in = 1'b0;
                     hold_cmd_in = cldr_pkg::CMD_ROW0;
                     hold_dat_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_SWEEP: begin
            pend_we  = sweep_pend_ff;
            shown_we = sweep_shown_ff;
            cnt_in   = cnt_ff + 1'b1;
            if (last_cell) begin
               state_in = sweep_rsp_ff ? ST_FLUSH : ST_IDLE;
            end
         end

         ST_SCAN: begin
            // A changed cell pushes the held result out and takes its place.
            if (diff && out_free) begin
               out_load    = 1'b1;
               hold_has_in = 1'b1;
               hold_cmd_in = cldr_pkg::addr_cmd(cnt_ff);
               hold_dat_in = pend_rd;
               shown_we    = 1'b1;
               shown_wdata = pend_rd;
            end
            // On a stall the same cell is read again so its data stays valid.
            if (advance) begin
               if (last_cell) begin
                  state_in = ST_FLUSH;
               end else begin
                  cnt_in  = cnt_ff + 1'b1;
                  rd_addr = cnt_ff + 1'b1;
               end
            end
         end

         ST_FLUSH: begin
            if (out_free) begin
               out_load = 1'b1;
               out_last = 1'b1;
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers; reset starts the clearing pass over both copies.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_SWEEP;
         cnt_ff         <= '0;
         sweep_pend_ff  <= 1'b1;
         sweep_shown_ff <= 1'b1;
         sweep_rsp_ff   <= 1'b0;
         sweep_val_ff   <= '0;
         empty_ff       <= cldr_pkg::EMPTY_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         cnt_ff         <= cnt_in;
         sweep_pend_ff  <= sweep_pend_in;
         sweep_shown_ff <= sweep_shown_in;
         sweep_rsp_ff   <= sweep_rsp_in;
         sweep_val_ff   <= sweep_val_in;
         if (csr.valid) begin
            empty_ff <= csr.empty_char;
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      hold_has_ff <= hold_has_in;
      hold_cmd_ff <= hold_cmd_in;
      hold_dat_ff <= hold_dat_in;
      if (out_load) begin
         rsp_has_ff  <= hold_has_ff;
         rsp_cmd_ff  <= hold_cmd_ff;
         rsp_dat_ff  <= hold_dat_ff;
         rsp_last_ff <= out_last;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.has_data     = rsp_has_ff;
   assign rsp.command_byte = rsp_cmd_ff;
   assign rsp.data_byte    = rsp_dat_ff;
   assign rsp.last_of_run  = rsp_last_ff;

   // A stalled scan keeps its place.
   `CLDR_ASSERT(a_scan_stall_holds, clock, reset,
      (state_ff == ST_SCAN && !advance) |=> (state_ff == ST_SCAN && $stable(cnt_ff)),
      "scan moved while stalled")
   // The scan ends with a flush after the last cell.
   `CLDR_ASSERT(a_scan_ends_flush, clock, reset,
      (state_ff == ST_SCAN && advance && last_cell) |=> (state_ff == ST_FLUSH),
      "scan did not flush at the end")
   // A sweep covers every cell before it leaves.
   `CLDR_ASSERT(a_sweep_runs, clock, reset,
      (state_ff == ST_SWEEP && !last_cell) |=> (state_ff == ST_SWEEP),
      "sweep ended early")
   // A result with data always carries a set-address command.
   `CLDR_ASSERT(a_data_has_addr, clock, reset,
      (rsp_valid_ff && rsp_has_ff) |-> rsp_cmd_ff[7],
      "data result without address command")
   // A command-only result carries a zero data byte.
   `CLDR_ASSERT(a_nodata_zero, clock, reset,
      (rsp_valid_ff && !rsp_has_ff) |-> (rsp_dat_ff == '0),
      "command-only result with data")

endmodule
